@@ sv/qsmp_pkg.sv @@
package qsmp_pkg;

  localparam int DataWidth = 32;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        final_res;
    logic                        truncated;
  } out_item_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

@@ sv/qsmp_cmp.sv @@
module qsmp_cmp import qsmp_pkg::*; (
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  output cmp_res_t                    res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

@@ sv/quicksort_middle_pivot.sv @@
// Load: one word per cycle; in_stall_o is high from the beat marked last until the set is out.
// Sort: per partition a pivot read, a scan of the words and a swap per out-of-place pair, plus a
// pop per stacked range; all through one element RAM read port, one write port and one comparator.
// Output: S_ORD opens the read, then one beat per cycle while out_stall_i stays low.
// Reset clears state, count, stack pointer, overflow flag and out_valid only; indices, pivot and
// output register are not reset. Store contents are undefined until loaded, stack ones until pushed.
module quicksort_middle_pivot import qsmp_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 2;

  typedef enum logic [10:0] {
    S_LOAD  = 11'b000_0000_0001,
    S_PIV   = 11'b000_0000_0010,
    S_PIVW  = 11'b000_0000_0100,
    S_ICMP  = 11'b000_0000_1000,
    S_JCMP  = 11'b000_0001_0000,
    S_SWAP  = 11'b000_0010_0000,
    S_SPLIT = 11'b000_0100_0000,
    S_POP   = 11'b000_1000_0000,
    S_POPW  = 11'b001_0000_0000,
    S_ORD   = 11'b010_0000_0000,
    S_OSH   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] k_q, k_d;
  logic          ovf_q, ovf_d;
  logic signed [SW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic signed [DataWidth-1:0] pivot_q, pivot_d, ai_q, ai_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // element store and range stack
  logic signed [DataWidth-1:0] mem_q [DEPTH];
  logic signed [DataWidth-1:0] mem_rdata_q, mem_wdata;
  logic [IW-1:0]               mem_raddr, mem_waddr;
  logic                        mem_we;
  logic [2*IW-1:0]             stack_q [DEPTH];
  logic [2*IW-1:0]             st_rdata_q, st_wdata;
  logic [IW-1:0]               st_raddr, st_waddr;
  logic                        st_we;

  logic [CW-1:0]        cnt_inc, sp_dec, k_inc;
  logic signed [SW-1:0] cnt_s, i_nxt, j_prv, left_len, right_len, lo_new, hi_new;
  logic [SW:0]          mid_sum;
  logic                 out_free, last_beat;
  cmp_res_t             cmp;

  qsmp_cmp u_cmp (
    .a_i   (mem_rdata_q),
    .b_i   (pivot_q),
    .res_o (cmp)
  );

  assign cnt_inc   = (count_q < CW'(DEPTH)) ? count_q + CW'(1) : count_q;
  assign cnt_s     = SW'(cnt_inc);
  assign sp_dec    = sp_q - CW'(1);
  assign k_inc     = k_q + CW'(1);
  assign last_beat = (k_inc == count_q);
  assign i_nxt     = i_q + SW'(1);
  assign j_prv     = j_q - SW'(1);
  assign left_len  = j_q - lo_q;
  assign right_len = hi_q - i_q;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sp_d        = sp_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    pivot_d     = pivot_q;
    ai_d        = ai_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata_q;
    st_raddr    = '0;
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = '0;
    lo_new      = lo_q;
    hi_new      = hi_q;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CW'(DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IW-1:0];
            mem_wdata = in_data_i.value;
            count_d   = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            k_d = '0;
            if (cnt_inc >= CW'(2)) begin
              lo_d    = '0;
              hi_d    = cnt_s - SW'(1);
              state_d = S_PIV;
            end else begin
              state_d = S_ORD;
            end
          end
        end
      end
      S_PIV: begin
        mem_raddr = mid_sum[IW:1];
        state_d   = S_PIVW;
      end
      S_PIVW: begin
        pivot_d   = mem_rdata_q;
        i_d       = lo_q;
        j_d       = hi_q;
        mem_raddr = lo_q[IW-1:0];
        state_d   = S_ICMP;
      end
      S_ICMP: begin
        if (i_q < hi_q && cmp.lt) begin
          i_d       = i_nxt;
          mem_raddr = i_nxt[IW-1:0];
        end else begin
          ai_d      = mem_rdata_q;
          mem_raddr = j_q[IW-1:0];
          state_d   = S_JCMP;
        end
      end
      S_JCMP: begin
        if (j_q > lo_q && cmp.gt) begin
          j_d       = j_prv;
          mem_raddr = j_prv[IW-1:0];
        end else if (i_q <= j_q) begin
          // first half of the swap: right word into the left slot
          mem_we    = 1'b1;
          mem_waddr = i_q[IW-1:0];
          mem_wdata = mem_rdata_q;
          state_d   = S_SWAP;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IW-1:0];
        mem_wdata = ai_q;
        i_d       = i_nxt;
        j_d       = j_prv;
        if (i_nxt <= j_prv) begin
          // i+1 stays below j here, so the read never meets the write
          mem_raddr = i_nxt[IW-1:0];
          state_d   = S_ICMP;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // push the larger part, carry on with the smaller one
        if (left_len < right_len) begin
          if (i_q < hi_q && sp_q < CW'(DEPTH)) begin
            st_we    = 1'b1;
            st_waddr = sp_q[IW-1:0];
            st_wdata = {i_q[IW-1:0], hi_q[IW-1:0]};
            sp_d     = sp_q + CW'(1);
          end
          hi_new = j_q;
        end else begin
          if (lo_q < j_q && sp_q < CW'(DEPTH)) begin
            st_we    = 1'b1;
            st_waddr = sp_q[IW-1:0];
            st_wdata = {lo_q[IW-1:0], j_q[IW-1:0]};
            sp_d     = sp_q + CW'(1);
          end
          lo_new = i_q;
        end
        lo_d    = lo_new;
        hi_d    = hi_new;
        state_d = (lo_new < hi_new) ? S_PIV : S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          sp_d     = sp_dec;
          st_raddr = sp_dec[IW-1:0];
          state_d  = S_POPW;
        end
      end
      S_POPW: begin
        lo_d    = SW'(st_rdata_q[2*IW-1:IW]);
        hi_d    = SW'(st_rdata_q[IW-1:0]);
        state_d = S_PIV;
      end
      S_ORD: begin
        mem_raddr = k_q[IW-1:0];
        state_d   = S_OSH;
      end
      S_OSH: begin
        mem_raddr = k_q[IW-1:0];
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = mem_rdata_q;
          out_d.final_res    = last_beat;
          out_d.truncated    = ovf_q;
          k_d                = k_inc;
          if (last_beat) begin
            count_d = '0;
            ovf_d   = 1'b0;
            sp_d    = '0;
            state_d = S_LOAD;
          end else begin
            mem_raddr = k_inc[IW-1:0];
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      sp_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sp_q        <= sp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    j_q     <= j_d;
    pivot_q <= pivot_d;
    ai_q    <= ai_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_q[st_waddr] <= st_wdata;
    end
    st_rdata_q <= stack_q[st_raddr];
  end

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count beyond store depth");

  a_stack_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(DEPTH))
    else $error("range stack pointer beyond depth");

  a_pivot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PIV) |-> (lo_q >= 0 && lo_q < hi_q && hi_q < $signed(SW'(count_q))))
    else $error("partition range outside the loaded set");

  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OSH) |-> (k_q < count_q))
    else $error("output index past the loaded set");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (sp_q == '0))
    else $error("range stack not empty while loading");

endmodule
